FILE: hw/rtl/meter_readout_frame_parser_macros.svh
// assertion macros shared by the parser rtl
`ifndef METER_READOUT_FRAME_PARSER_MACROS_SVH
`define METER_READOUT_FRAME_PARSER_MACROS_SVH

// clocked check, masked while reset is asserted
`define MRFP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mrfp check failed");

// clocked check that also holds during reset
`define MRFP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("mrfp check failed");

`endif

FILE: hw/rtl/mrfp_pkg.sv
package mrfp_pkg;

	localparam int ID_MAX     = 16;
	localparam int CODE_MAX   = 16;
	localparam int VALUE_MAX  = 32;
	localparam int UNIT_MAX   = 16;
	localparam int SYNC_LIMIT = 1024;

	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_QMARK = 8'h3f;

	localparam logic [1:0] REG_MAX_RECORDS = 2'd0;
	localparam logic [1:0] REG_ACK_MODE    = 2'd1;
	localparam logic [1:0] REG_WAIT_SYNC   = 2'd2;

	localparam logic [1:0] ACK_FIXED = 2'd1;
	localparam logic [1:0] ACK_AUTO  = 2'd2;

	localparam logic [2:0] CLS_CONSUMED = 3'd0;
	localparam logic [2:0] CLS_VENDOR   = 3'd1;
	localparam logic [2:0] CLS_BAUD     = 3'd2;
	localparam logic [2:0] CLS_IDENT    = 3'd3;
	localparam logic [2:0] CLS_CODE     = 3'd4;
	localparam logic [2:0] CLS_VALUE    = 3'd5;
	localparam logic [2:0] CLS_UNIT     = 3'd6;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_ACCEPTED = 3'd1;
	localparam logic [2:0] EV_REJECTED = 3'd2;
	localparam logic [2:0] EV_ACK      = 3'd3;
	localparam logic [2:0] EV_END      = 3'd4;
	localparam logic [2:0] EV_ERROR    = 3'd5;
	localparam logic [2:0] EV_SYNC     = 3'd6;

	typedef enum logic [3:0] {
		ST_START,
		ST_VENDOR,
		ST_BAUD,
		ST_IDENT,
		ST_ACK,
		ST_CODE,
		ST_VALUE,
		ST_UNIT,
		ST_END
	} stage_t;

	typedef struct packed {
		logic [7:0] max_records;
		logic [1:0] ack_mode;
	} cfg_t;

	typedef struct packed {
		stage_t      stage;
		logic [5:0]  field_count;
		logic [7:0]  baud_char;
		logic [7:0]  code_first_char;
		logic        value_nonempty;
		logic [7:0]  tuple_count;
		logic        question_seen;
		logic        sync_pending;
		logic [10:0] sync_skipped;
		logic [2:0]  latched_baud_code;
		logic        ack_latched;
		logic        fast_flag;
		logic        finished;
	} state_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [2:0] byte_class;
		logic [2:0] event_res;
		logic [2:0] baud_code;
		logic       fast_reaction;
		logic [7:0] record_count;
		logic       read_done;
	} result_t;

endpackage

FILE: hw/rtl/mrfp_step.sv
module mrfp_step
	import mrfp_pkg::*;
(
	input  cfg_t       cfg,
	input  state_t     st,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output state_t     st_next,
	output result_t    res
);

	state_t     nx;
	logic [7:0] b;
	logic [2:0] cls;
	logic [2:0] ev;
	stage_t     stg;
	logic [5:0] fc;
	logic       qs;
	logic       is_alpha;
	logic       is_lower;
	logic       is_eol;
	logic       ok_first;
	logic       rec_ok;

	assign is_lower = (rx_byte >= 8'h61) && (rx_byte <= 8'h7a);
	assign is_alpha = is_lower || ((rx_byte >= 8'h41) && (rx_byte <= 8'h5a));
	assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign ok_first = ((st.code_first_char >= 8'h30) && (st.code_first_char <= 8'h39))
		|| (st.code_first_char == 8'h43) || (st.code_first_char == 8'h46);
	assign rec_ok   = (st.tuple_count < cfg.max_records) && (st.code_first_char != 8'h00)
		&& st.value_nonempty && ok_first;

	always_comb begin
		nx  = st;
		b   = rx_byte;
		cls = CLS_CONSUMED;
		ev  = EV_NONE;
		stg = st.stage;
		fc  = st.field_count;
		qs  = st.question_seen;
		if (action) begin
			nx.stage           = ST_START;
			nx.field_count     = '0;
			nx.baud_char       = '0;
			nx.code_first_char = '0;
			nx.value_nonempty  = 1'b0;
			nx.tuple_count     = '0;
			nx.question_seen   = 1'b0;
			nx.finished        = 1'b0;
			b                  = '0;
		end else if (st.finished) begin
			nx = st;
		end else if (st.sync_pending) begin
			if (rx_byte == CH_BANG || st.sync_skipped >= 11'(SYNC_LIMIT)) begin
				nx.sync_pending = 1'b0;
				ev              = EV_SYNC;
			end else begin
				nx.sync_skipped = st.sync_skipped + 11'd1;
			end
		end else begin
			// slash at field start or an end mark redirects before dispatch
			if (rx_byte == CH_SLASH && st.field_count == 6'd0) begin
				stg = ST_VENDOR;
			end else if ((rx_byte == CH_QMARK || rx_byte == CH_BANG) && st.stage != ST_END) begin
				stg = ST_END;
				fc  = '0;
				qs  = 1'b0;
			end
			nx.stage         = stg;
			nx.field_count   = fc;
			nx.question_seen = qs;
			unique case (stg)
				ST_START: begin
					nx.stage = ST_START;
				end
				ST_VENDOR: begin
					if (is_eol || rx_byte == CH_SLASH) begin
						nx.field_count = '0;
						nx.tuple_count = '0;
					end else if (!is_alpha) begin
						nx.finished = 1'b1;
						ev          = EV_ERROR;
					end else begin
						cls = CLS_VENDOR;
						if (fc + 6'd1 >= 6'd3) begin
							nx.fast_flag   = is_lower;
							nx.field_count = '0;
							nx.stage       = ST_BAUD;
						end else begin
							nx.field_count = fc + 6'd1;
						end
					end
				end
				ST_BAUD: begin
					nx.baud_char   = rx_byte;
					cls            = CLS_BAUD;
					nx.field_count = '0;
					nx.stage       = ST_IDENT;
				end
				ST_IDENT: begin
					if (is_eol) begin
						nx.field_count = '0;
						nx.stage       = ST_ACK;
					end else if (rx_byte >= 8'h20 && rx_byte <= 8'h7e && fc < 6'(ID_MAX)) begin
						nx.field_count = fc + 6'd1;
						cls            = CLS_IDENT;
					end
				end
				ST_ACK: begin
					if (cfg.ack_mode == ACK_FIXED || cfg.ack_mode == ACK_AUTO) begin
						if (cfg.ack_mode == ACK_AUTO && !st.ack_latched) begin
							// '1'..'6' map straight to their low bits
							nx.latched_baud_code = (st.baud_char >= 8'h31 && st.baud_char <= 8'h36)
								? st.baud_char[2:0] : 3'd0;
							nx.ack_latched = 1'b1;
						end
						ev = EV_ACK;
					end
					nx.stage = ST_CODE;
				end
				ST_CODE: begin
					if (!is_eol && rx_byte != CH_STX) begin
						if (rx_byte == CH_LPAR) begin
							if (fc == 6'd0) begin
								nx.code_first_char = '0;
							end
							nx.field_count    = '0;
							nx.value_nonempty = 1'b0;
							nx.stage          = ST_VALUE;
						end else if (fc < 6'(CODE_MAX)) begin
							if (fc == 6'd0) begin
								nx.code_first_char = rx_byte;
							end
							nx.field_count = fc + 6'd1;
							cls            = CLS_CODE;
						end
					end
				end
				ST_VALUE, ST_UNIT: begin
					if (rx_byte == CH_RPAR) begin
						if (rec_ok) begin
							nx.tuple_count = st.tuple_count + 8'd1;
							ev             = EV_ACCEPTED;
						end else begin
							ev = EV_REJECTED;
						end
						nx.field_count = '0;
						nx.stage       = ST_CODE;
					end else if (stg == ST_VALUE) begin
						if (rx_byte == CH_STAR) begin
							nx.field_count = '0;
							nx.stage       = ST_UNIT;
						end else if (fc < 6'(VALUE_MAX)) begin
							if (fc == 6'd0) begin
								nx.value_nonempty = (rx_byte != 8'h00);
							end
							nx.field_count = fc + 6'd1;
							cls            = CLS_VALUE;
						end
					end else if (fc < 6'(UNIT_MAX)) begin
						nx.field_count = fc + 6'd1;
						cls            = CLS_UNIT;
					end
				end
				default: begin
					// end sequence
					if (rx_byte == CH_BANG) begin
						if (qs) begin
							nx.stage         = ST_VENDOR;
							nx.field_count   = '0;
							nx.question_seen = 1'b0;
						end else begin
							nx.finished = 1'b1;
							ev          = EV_END;
						end
					end else if (rx_byte == CH_QMARK) begin
						nx.question_seen = 1'b1;
						nx.field_count   = 6'd1;
					end else if (rx_byte == CH_STX) begin
						nx.stage         = ST_CODE;
						nx.field_count   = '0;
						nx.question_seen = 1'b0;
					end else if (rx_byte == CH_SLASH) begin
						nx.stage         = ST_VENDOR;
						nx.field_count   = '0;
						nx.question_seen = 1'b0;
					end else begin
						nx.field_count   = '0;
						nx.question_seen = 1'b0;
					end
				end
			endcase
		end
	end

	assign st_next           = nx;
	assign res.byte_out      = b;
	assign res.byte_class    = cls;
	assign res.event_res     = ev;
	assign res.baud_code     = nx.latched_baud_code;
	assign res.fast_reaction = nx.fast_flag;
	assign res.record_count  = nx.tuple_count;
	assign res.read_done     = nx.finished;

endmodule

FILE: hw/rtl/meter_readout_frame_parser.sv
// channel  | dir | tdata                                        | tuser
// s_*      | in  | [7:0] rx_byte                                | [0] action
// m_*      | out | [7:0] byte_out, [10:8] event_res,            | [2:0] byte_class
//          |     | [13:11] baud_code, [14] fast_reaction,       |
//          |     | [22:15] record_count, [23] read_done         |
// cfg_*    | in  | cfg_index selects register, cfg_wdata value  |
//
// one beat per cycle while m_tready is high; an s beat reaches the m side through
// the input register, one pass of the parse logic and the result register
// parser state advances as a beat moves from the input to the result register
// s_tready drops only when both registers are full and m_tready is low
// arst_n clears control and parser state; no clearing pass
`include "meter_readout_frame_parser_macros.svh"

module meter_readout_frame_parser
	import mrfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // byte_out, event_res, baud_code, fast_reaction,
	                               // record_count, read_done
	output logic [2:0]  m_tuser,   // [2:0] byte_class
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic       in_valid_s1;
	logic       in_action_s1;
	logic [7:0] in_byte_s1;
	logic       res_valid_s2;
	result_t    res_s2;
	cfg_t       cfg_q;
	state_t     st_q;
	state_t     st_next;
	result_t    res_next;
	logic       advance;
	logic       s_accept;

	assign advance  = in_valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	mrfp_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.action  (in_action_s1),
		.rx_byte (in_byte_s1),
		.st_next (st_next),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (s_accept) begin
				in_valid_s1 <= 1'b1;
			end else if (advance) begin
				in_valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			in_action_s1 <= s_tuser;
			in_byte_s1   <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	// all-zero state is the start stage with every counter cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_records <= 8'd32;
			cfg_q.ack_mode    <= 2'd0;
			st_q              <= '0;
		end else begin
			if (advance) begin
				st_q <= st_next;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_RECORDS: cfg_q.max_records <= cfg_wdata;
					REG_ACK_MODE:    cfg_q.ack_mode    <= cfg_wdata[1:0];
					REG_WAIT_SYNC: begin
						st_q.sync_pending <= cfg_wdata[0];
						st_q.sync_skipped <= '0;
					end
					default: begin
						cfg_q <= cfg_q;
					end
				endcase
			end
		end
	end

	assign m_tvalid = res_valid_s2;
	assign m_tuser  = res_s2.byte_class;
	assign m_tdata  = {res_s2.read_done, res_s2.record_count, res_s2.fast_reaction,
		res_s2.baud_code, res_s2.event_res, res_s2.byte_out};

	// input side only stalls when both stages hold a beat and the output is blocked
	`MRFP_ASSERT(a_stall_only_full, !s_tready |-> (in_valid_s1 && res_valid_s2 && !m_tready))
	// no field ever counts past the longest field limit
	`MRFP_ASSERT(a_field_bound, st_q.field_count <= 6'(VALUE_MAX))
	// the latched baud code stays within 0..6
	`MRFP_ASSERT(a_baud_range, st_q.latched_baud_code <= 3'd6)
	// the ack latch is set once and kept
	`MRFP_ASSERT(a_ack_latch_holds, st_q.ack_latched |=> st_q.ack_latched)
	// no result beat right after a reset edge
	`MRFP_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !m_tvalid)

endmodule
